// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sorted queue RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define SSPQ_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// Condition on one edge implies a consequence on the same edge
`define SSPQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition on one edge implies a consequence on the next edge
`define SSPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sspq_pkg.sv -----
// ---------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the sorted priority queue cells and top.
// ---------------------------------------------------------------------------
package sspq_pkg;

    localparam int PRIO_W    = 8;
    localparam int PAYLOAD_W = 16;
    localparam int OCC_W     = 5;
    localparam int STATUS_W  = 2;

    // command codes (s_tuser)
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // operation broadcast to every cell in the row
    typedef struct packed {
        logic              ins_en;
        logic              rem_en;
        logic [PRIO_W-1:0] prio;
    } sspq_ctrl_t;

endpackage

// ----- hdl/sspq_cell.sv -----
// ---------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted row: holds a priority and payload, and on each
// operation keeps, takes its left neighbor, takes the new entry, or takes
// its right neighbor.
// ---------------------------------------------------------------------------
module sspq_cell
    import sspq_pkg::*;
#(
    parameter int PW = 16
) (
    input  logic              aclk,
    input  sspq_ctrl_t        ctrl,
    input  logic [PW-1:0]     new_payload,
    input  logic              occupied,
    input  logic              prev_gt,
    input  logic [PRIO_W-1:0] prev_prio,
    input  logic [PW-1:0]     prev_payload,
    input  logic [PRIO_W-1:0] next_prio,
    input  logic [PW-1:0]     next_payload,
    output logic              gt,
    output logic [PRIO_W-1:0] prio,
    output logic [PW-1:0]     payload
);

    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [PW-1:0]     payload_reg;
    logic [PW-1:0]     payload_next;

    // slot is free or holds a strictly larger number: new entry lands here or left
    assign gt = !occupied || (prio_reg > ctrl.prio);

    always_comb begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.ins_en && gt) begin
            if (prev_gt) begin
                // shift right by one
                prio_next    = prev_prio;
                payload_next = prev_payload;
            end else begin
                // insertion point
                prio_next    = ctrl.prio;
                payload_next = new_payload;
            end
        end else if (ctrl.rem_en) begin
            // shift left by one
            prio_next    = next_prio;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

// ----- hdl/stable_sorted_priority_queue_core.sv -----
// The result beat is registered: it appears in the cycle after its input beat is accepted.
// Throughput: one command per cycle while m_tready is high; every cell of the
// row updates in the same cycle for both insert and remove.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents stay undefined until written and are never read.
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Bounded priority queue as a row of sorted cells, stable among equals.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue_core
    import sspq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] priority_req, [23:8] payload
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_priority, [23:8] out_payload,
                                   // [28:24] occupancy, [31:29] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    `include "assert_macros.svh"

    localparam int SW    = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [PRIO_W-1:0]    oprio_reg;
    logic [PRIO_W-1:0]    oprio_next;
    logic [PAYLOAD_W-1:0] opay_reg;
    logic [PAYLOAD_W-1:0] opay_next;

    logic                 accept;
    logic                 cmd;
    logic                 full;
    logic                 empty;
    sspq_ctrl_t           ctrl;
    logic [SW-1:0]        new_payload;

    logic                 gt_w      [DEPTH];
    logic [PRIO_W-1:0]    prio_w    [DEPTH];
    logic [SW-1:0]        payload_w [DEPTH];

    // handshake: output register frees up when taken downstream
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser[0];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign new_payload = s_tdata[8 +: SW];
    assign ctrl.prio   = s_tdata[7:0];
    assign ctrl.ins_en = accept && (cmd == CMD_INSERT) && !full;
    assign ctrl.rem_en = accept && (cmd == CMD_REMOVE) && !empty;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              prev_gt;
        logic [PRIO_W-1:0] prev_prio;
        logic [SW-1:0]     prev_payload;
        logic [PRIO_W-1:0] next_prio;
        logic [SW-1:0]     next_payload;

        if (i == 0) begin : g_first
            assign prev_gt      = 1'b0;
            assign prev_prio    = '0;
            assign prev_payload = '0;
        end else begin : g_mid
            assign prev_gt      = gt_w[i-1];
            assign prev_prio    = prio_w[i-1];
            assign prev_payload = payload_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_prio    = '0;
            assign next_payload = '0;
        end else begin : g_inner
            assign next_prio    = prio_w[i+1];
            assign next_payload = payload_w[i+1];
        end

        sspq_cell #(
            .PW (SW)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .new_payload  (new_payload),
            .occupied     (CNT_W'(i) < count_reg),
            .prev_gt      (prev_gt),
            .prev_prio    (prev_prio),
            .prev_payload (prev_payload),
            .next_prio    (next_prio),
            .next_payload (next_payload),
            .gt           (gt_w[i]),
            .prio         (prio_w[i]),
            .payload      (payload_w[i])
        );
    end

    // count and result for the accepted beat
    always_comb begin
        count_next  = count_reg;
        status_next = ST_DONE;
        oprio_next  = '0;
        opay_next   = '0;
        if (cmd == CMD_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                count_next = count_reg - 1'b1;
                oprio_next = prio_w[0];
                opay_next  = PAYLOAD_W'(payload_w[0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            oprio_reg  <= oprio_next;
            opay_reg   <= opay_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, OCC_W'(count_reg), opay_reg, oprio_reg};

    // checks
    `SSPQ_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH),
        "occupancy exceeds depth")
    `SSPQ_ASSERT_SAME(a_front_sorted, aclk, aresetn, count_reg >= CNT_W'(2),
        prio_w[0] <= prio_w[1], "front cells out of order")
    `SSPQ_ASSERT_NEXT(a_empty_status, aclk, aresetn,
        accept && (cmd == CMD_REMOVE) && empty,
        m_tvalid && (m_tuser == ST_EMPTY) && (count_reg == '0),
        "remove on empty queue not reported")
    `SSPQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, ctrl.ins_en,
        count_reg == $past(count_reg) + 1'b1, "insert did not grow occupancy")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the sorted priority queue core against a behavioral queue that
// keeps its own sorted entry list. Every accepted command beat updates that
// list and queues the expected result beat. Each result beat is checked
// field by field against the oldest queued result. The run has three
// phases: sender idles lightly while receiver stalls heavily, then the
// reverse, then no idling at all.
// ---------------------------------------------------------------------------
module testbench;
    import sspq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int PAY_BITS   = 16;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASE_ITEMS = 184;

    // one command beat
    typedef struct packed {
        logic                 cmd;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
    } queue_cmd_t;

    // one result beat
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
        logic [OCC_W-1:0]     occ;
    } queue_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // [7:0] priority_req, [23:8] payload
    logic [0:0]  s_tuser = '0;    // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [7:0] out_priority, [23:8] out_payload,
                                  // [28:24] occupancy, [31:29] zero
    logic [1:0]  m_tuser;         // [1:0] status

    queue_cmd_t    cmd_backlog[$];
    queue_result_t pending_results[$];
    queue_cmd_t    beat_out;

    // behavioral queue, front at index 0
    logic [PRIO_W-1:0]    sorted_prio[QDEPTH];
    logic [PAYLOAD_W-1:0] sorted_pay[QDEPTH];
    int                   stored_count = 0;

    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    stable_sorted_priority_queue_core #(
        .DEPTH        (QDEPTH),
        .PAYLOAD_BITS (PAY_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the sorted list and return the result it yields
    function automatic queue_result_t serve_command(queue_cmd_t c);
        queue_result_t r;
        int pos;
        r = '0;
        r.status = ST_DONE;
        if (c.cmd == CMD_INSERT) begin
            if (stored_count >= QDEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry lands behind every entry with an equal or smaller number
                pos = 0;
                while (pos < stored_count && sorted_prio[pos] <= c.prio)
                    pos++;
                for (int i = stored_count; i > pos; i--) begin
                    sorted_prio[i] = sorted_prio[i-1];
                    sorted_pay[i]  = sorted_pay[i-1];
                end
                sorted_prio[pos] = c.prio;
                sorted_pay[pos]  = c.payload;
                stored_count++;
            end
        end else begin
            if (stored_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.prio    = sorted_prio[0];
                r.payload = sorted_pay[0];
                for (int i = 1; i < stored_count; i++) begin
                    sorted_prio[i-1] = sorted_prio[i];
                    sorted_pay[i-1]  = sorted_pay[i];
                end
                stored_count--;
            end
        end
        r.occ = stored_count[OCC_W-1:0];
        return r;
    endfunction

    // Command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                beat_out = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= beat_out.cmd;
                s_tdata  <= {beat_out.payload, beat_out.prio};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: check result beats, then predict from accepted command beats
    always @(posedge aclk) begin : monitor_proc
        queue_result_t want;
        queue_cmd_t    got_cmd;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat status=%0d prio=%0d pay=%h occ=%0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[28:24]);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status || m_tdata[7:0] !== want.prio ||
                        m_tdata[23:8] !== want.payload || m_tdata[28:24] !== want.occ ||
                        m_tdata[31:29] !== 3'b000) begin
                        $display("%0t: mismatch expected status=%0d prio=%0d pay=%h occ=%0d pad=0",
                                 $time, want.status, want.prio, want.payload, want.occ);
                        $display("%0t:          actual status=%0d prio=%0d pay=%h occ=%0d pad=%0d",
                                 $time, m_tuser, m_tdata[7:0], m_tdata[23:8],
                                 m_tdata[28:24], m_tdata[31:29]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                got_cmd.cmd     = s_tuser[0];
                got_cmd.prio    = s_tdata[7:0];
                got_cmd.payload = s_tdata[23:8];
                pending_results.push_back(serve_command(got_cmd));
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_cmd(logic cmd, int prio, int payload);
        queue_cmd_t c;
        c.cmd     = cmd;
        c.prio    = prio[PRIO_W-1:0];
        c.payload = payload[PAYLOAD_W-1:0];
        cmd_backlog.push_back(c);
    endtask

    // Random bursts that lean toward filling, draining or neither, so the queue
    // swings between empty and full; narrow priority ranges force ties
    task automatic load_random(int count);
        int burst;
        int lean;
        int prio;
        int pick;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            lean  = $urandom_range(0, 2);
            for (int k = 0; k < burst && count > 0; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    prio = $urandom_range(0, 255);
                else if (pick < 8)
                    prio = $urandom_range(0, 3);
                else
                    prio = $urandom_range(0, 1) ? 255 : 0;
                case (lean)
                    0: pick = $urandom_range(0, 99) < 80;
                    1: pick = $urandom_range(0, 99) < 20;
                    default: pick = $urandom_range(0, 99) < 50;
                endcase
                push_cmd(pick ? CMD_INSERT : CMD_REMOVE, prio, $urandom_range(0, 65535));
                count--;
            end
        end
    endtask

    // Wait until every command is accepted and every result has come back
    task automatic drain();
        while (cmd_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: light sender idling, heavy receiver stalls
        send_idle_pct  <= 20;
        recv_stall_pct <= 84;

        // remove on empty
        push_cmd(CMD_REMOVE, 0, 0);
        // extremes and ties at low, middle and high priority
        push_cmd(CMD_INSERT, 128, 16'h0000);
        push_cmd(CMD_INSERT, 0,   16'hFFFF);
        push_cmd(CMD_INSERT, 255, 16'hA5A5);
        push_cmd(CMD_INSERT, 128, 16'h0001);
        push_cmd(CMD_INSERT, 128, 16'h0002);
        push_cmd(CMD_INSERT, 0,   16'h5A5A);
        push_cmd(CMD_INSERT, 255, 16'h1234);
        push_cmd(CMD_INSERT, 7,   16'h8000);
        push_cmd(CMD_INSERT, 200, 16'h7FFF);
        push_cmd(CMD_INSERT, 64,  16'hC3C3);
        push_cmd(CMD_INSERT, 128, 16'h0003);
        push_cmd(CMD_INSERT, 1,   16'h3C3C);
        push_cmd(CMD_INSERT, 254, 16'hF00F);
        push_cmd(CMD_INSERT, 32,  16'h0FF0);
        push_cmd(CMD_INSERT, 96,  16'h5555);
        push_cmd(CMD_INSERT, 160, 16'hAAAA);
        // queue is full now: insert refused
        push_cmd(CMD_INSERT, 50,  16'hBEEF);
        repeat (6) push_cmd(CMD_REMOVE, 0, 0);
        drain();

        load_random(PHASE_ITEMS);
        drain();

        // phase 2: heavy sender idling, light receiver stalls
        send_idle_pct  <= 84;
        recv_stall_pct <= 20;
        load_random(PHASE_ITEMS);
        drain();

        // phase 3: no idling on either side
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        load_random(PHASE_ITEMS);
        drain();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- stable_sorted_priority_queue_core.f -----
+incdir+hdl
hdl/sspq_pkg.sv
hdl/sspq_cell.sv
hdl/stable_sorted_priority_queue_core.sv
test/testbench.sv
